### hdl/llas_pkg.sv
// ----------------------------------------------------------------------------
// llas_pkg
// Shared types and constants for the Life-like automaton step core: command
// and result transactions, opcodes, rule masks and register indexes.
// ----------------------------------------------------------------------------
package llas_pkg;

  // Field widths of a command and a result, the rule masks, neighbor counts and config indexes
  localparam int RowW     = 6;
  localparam int ColW     = 6;
  localparam int GenW     = 32;
  localparam int MaskW    = 9;
  localparam int CountW   = 4;
  localparam int CfgIdxW  = 2;

  // Rule masks after reset: born on three, survives on two or three
  localparam logic [MaskW-1:0] BirthMaskRst   = MaskW'(8);
  localparam logic [MaskW-1:0] SurviveMaskRst = MaskW'(12);

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_BIRTH   = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_SURVIVE = CfgIdxW'(1);

  typedef logic [MaskW-1:0] mask_t;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2
  } op_e;

  typedef struct packed {
    op_e             opcode;
    logic [RowW-1:0] row;
    logic [ColW-1:0] column;
    logic            cell_in;
  } cmd_t;

  typedef struct packed {
    logic            cell_out;
    logic [GenW-1:0] generation;
  } result_t;

endpackage

### hdl/llas_row_cell.sv
// ----------------------------------------------------------------------------
// llas_row_cell
// One link of the row ring: holds one grid row and takes the row of its
// neighbor on every shift cycle. Reset clears the row to all dead.
// ----------------------------------------------------------------------------
module llas_row_cell #(
  parameter int SIDE = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  logic [SIDE-1:0] row_i,
  output logic [SIDE-1:0] row_o
);

  logic [SIDE-1:0] row_q;

  // Row storage, shifted along the ring
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else if (shift_i) begin
      row_q <= row_i;
    end
  end

  assign row_o = row_q;

endmodule

### hdl/llas_rule_row.sv
// ----------------------------------------------------------------------------
// llas_rule_row
// Next state of one whole row: one lane per column counts the eight wrapped
// neighbors from the rows above, at and below, then looks up the rule mask.
// ----------------------------------------------------------------------------
module llas_rule_row #(
  parameter int SIDE = 64
) (
  input  logic [SIDE-1:0]      prev_i,
  input  logic [SIDE-1:0]      curr_i,
  input  logic [SIDE-1:0]      next_i,
  input  llas_pkg::mask_t      birth_mask_i,
  input  llas_pkg::mask_t      survive_mask_i,
  output logic [SIDE-1:0]      row_o
);

  import llas_pkg::*;

  // One lane per column, neighbors wrap at the row ends
  for (genvar j = 0; j < SIDE; j++) begin : g_lane
    localparam int Left  = (j + SIDE - 1) % SIDE;
    localparam int Right = (j + 1) % SIDE;

    logic [CountW-1:0] count;

    assign count = CountW'($countones({prev_i[Left], prev_i[j], prev_i[Right],
                                       curr_i[Left], curr_i[Right],
                                       next_i[Left], next_i[j], next_i[Right]}));

    assign row_o[j] = curr_i[j] ? survive_mask_i[count] : birth_mask_i[count];
  end

endmodule

### hdl/life_like_automaton_step_core.sv
// ----------------------------------------------------------------------------
// life_like_automaton_step_core
// Life-like automaton on a SIDE x SIDE torus. The grid lives in a ring of
// row cells that rotates once per command; reads, writes and generations all
// act on the row passing the head of the ring.
//
//   channel   | direction | handshake                 | payload
//   ----------+-----------+---------------------------+----------------------
//   command   | in        | start_i, busy_o           | cmd_i    (cmd_t)
//   result    | out       | done_o (one-cycle strobe) | result_o (result_t)
//   config    | in        | cfg_valid_i, cfg_ready_o  | cfg_index_i, cfg_data_i
//
// The row ring rotates one row per cycle while busy_o is high, starting at the
// accepting edge, until the whole ring has turned once; the result is registered
// with the last shift, at the same edge that raises done_o and drops busy_o.
// A command is accepted when start_i is high and busy_o low;
// the next one may be accepted in the cycle that shows done_o.
// The receiver cannot stall: done_o is high for exactly one cycle.
// Reset clears the grid, the generation counter and loads rule B3/S23.
// Configuration is taken only while no command is running.
// ----------------------------------------------------------------------------
module life_like_automaton_step_core #(
  parameter int SIDE = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  llas_pkg::cmd_t                cmd_i,
  output logic                          done_o,
  output llas_pkg::result_t             result_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [llas_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  llas_pkg::mask_t               cfg_data_i
);

  import llas_pkg::*;

  localparam int IdxW = $clog2(SIDE);
  localparam int CmpW = (IdxW > RowW) ? IdxW : RowW;
  localparam logic [IdxW-1:0] LastRow = IdxW'(SIDE - 1);

  logic              busy_q, busy_d;
  logic              done_q;
  logic [IdxW-1:0]   cnt_q;
  cmd_t              cmd_q;
  logic              inside_q;
  logic [SIDE-1:0]   prev_q;
  logic [SIDE-1:0]   first_q;
  logic              cell_q;
  logic [GenW-1:0]   gen_q;
  mask_t             birth_q;
  mask_t             survive_q;

  logic [SIDE-1:0]   ring [SIDE];
  logic [SIDE-1:0]   head;
  logic [SIDE-1:0]   next_row;
  logic [SIDE-1:0]   rule_row;
  logic [SIDE-1:0]   tail_row;
  logic [SIDE-1:0]   col_sel;
  logic [SIDE-1:0]   patched;
  logic              accept;
  logic              last;
  logic              row_hit;

  assign accept = start_i && !busy_q;
  assign last   = busy_q && (cnt_q == LastRow);

  // Ring of row cells; new rows enter at the tail
  for (genvar i = 0; i < SIDE; i++) begin : g_ring
    logic [SIDE-1:0] feed;
    if (i == SIDE - 1) begin : g_tail
      assign feed = tail_row;
    end else begin : g_link
      assign feed = ring[i+1];
    end
    llas_row_cell #(.SIDE(SIDE)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(busy_q),
      .row_i  (feed),
      .row_o  (ring[i])
    );
  end

  assign head = ring[0];

  // Row below the head: on the last row it wraps to the saved old row 0
  assign next_row = (cnt_q == LastRow) ? first_q : ring[1];

  llas_rule_row #(.SIDE(SIDE)) u_rule (
    .prev_i        (prev_q),
    .curr_i        (head),
    .next_i        (next_row),
    .birth_mask_i  (birth_q),
    .survive_mask_i(survive_q),
    .row_o         (rule_row)
  );

  // Column decode of the addressed cell
  always_comb begin
    for (int j = 0; j < SIDE; j++) begin
      col_sel[j] = (CmpW'(j) == CmpW'(cmd_q.column));
    end
  end

  assign row_hit = inside_q && (CmpW'(cnt_q) == CmpW'(cmd_q.row));
  assign patched = (head & ~col_sel) | (col_sel & {SIDE{cmd_q.cell_in}});

  // Row written back at the tail
  always_comb begin
    case (cmd_q.opcode)
      OP_WRITE: tail_row = row_hit ? patched : head;
      OP_STEP:  tail_row = rule_row;
      default:  tail_row = head;
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      done_q    <= 1'b0;
      cnt_q     <= '0;
      cell_q    <= 1'b0;
      gen_q     <= '0;
      birth_q   <= BirthMaskRst;
      survive_q <= SurviveMaskRst;
    end else begin
      busy_q <= busy_d;
      done_q <= last;
      if (accept) begin
        cnt_q  <= '0;
        cell_q <= 1'b0;
      end else if (busy_q) begin
        cnt_q <= last ? '0 : cnt_q + IdxW'(1);
        if (row_hit && (cmd_q.opcode == OP_READ)) begin
          cell_q <= |(head & col_sel);
        end
        if (last && (cmd_q.opcode == OP_STEP)) begin
          gen_q <= gen_q + GenW'(1);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_BIRTH:   birth_q   <= cfg_data_i;
          CFG_SURVIVE: survive_q <= cfg_data_i;
          default:     ;
        endcase
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (last) begin
      busy_d = 1'b0;
    end
  end

  // Command latch and neighbor rows for the sweep
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= cmd_i;
      inside_q <= (32'(cmd_i.row) < 32'(SIDE)) && (32'(cmd_i.column) < 32'(SIDE));
      prev_q   <= ring[SIDE-1];
      first_q  <= ring[0];
    end else if (busy_q) begin
      prev_q <= head;
    end
  end

  assign busy_o              = busy_q;
  assign done_o              = done_q;
  assign cfg_ready_o         = !busy_q;
  assign result_o.cell_out   = cell_q;
  assign result_o.generation = gen_q;

  // Checks
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("done strobe while a command is still running");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("done strobe longer than one cycle");

  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (cnt_q == '0))
    else $error("row counter not parked while idle");

  a_gen_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (cmd_q.opcode != OP_STEP)) |-> $stable(gen_q))
    else $error("generation count moved on a non-step command");

endmodule

### tb/life_like_automaton_step_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_like_automaton_step_core_tb
// Self-checking bench for the Life-like automaton step core. A predictor
// class keeps its own copy of both grid buffers, the generation counter and
// the rule masks, and queues one expected result per accepted command. Each
// done strobe is checked field by field against the oldest expectation.
// Stimulus opens with a short directed run: corners, wrap across the torus
// seams and the unused opcode. It then goes through several rule settings,
// the extremes among them. Each setting runs random episodes: local writes,
// generations, then reads around the same spot, with some noise commands.
// ----------------------------------------------------------------------------
module life_like_automaton_step_core_tb;
  import llas_pkg::*;

  localparam int Side = 64;
  localparam int ItemsPerRule = 194;
  localparam logic [1:0] OpUnused = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgSpareLo = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgSpareHi = CfgIdxW'(3);

  // --------------------------------------------------------------------------
  // Predictor and store of expected results
  // --------------------------------------------------------------------------
  class life_predictor;
    logic [Side-1:0] cells [2][Side];
    bit              page;
    logic [GenW-1:0] gen_count;
    mask_t           birth;
    mask_t           survive;
    result_t         expected_results [$];
    int              mismatches;
    int              steps_seen;
    int              live_reads;

    function new();
      for (int p = 0; p < 2; p++) begin
        for (int r = 0; r < Side; r++) cells[p][r] = '0;
      end
      page       = 1'b0;
      gen_count  = '0;
      birth      = BirthMaskRst;
      survive    = SurviveMaskRst;
      mismatches = 0;
      steps_seen = 0;
      live_reads = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      mismatches++;
    endtask

    function void set_register(logic [CfgIdxW-1:0] idx, mask_t data);
      if (idx == CFG_BIRTH) birth = data;
      else if (idx == CFG_SURVIVE) survive = data;
    endfunction

    // One generation: wrapped eight-neighbour count into the other buffer
    function void advance();
      int    n;
      logic  alive;
      mask_t m;
      for (int r = 0; r < Side; r++) begin
        for (int c = 0; c < Side; c++) begin
          n = 0;
          for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
              if (dr != 0 || dc != 0)
                n += cells[page][(r + dr + Side) % Side][(c + dc + Side) % Side];
            end
          end
          alive = cells[page][r][c];
          m = alive ? survive : birth;
          cells[!page][r][c] = m[n];
        end
      end
      page = !page;
      gen_count = gen_count + 1'b1;
      steps_seen++;
    endfunction

    function void accept_cmd(cmd_t cmd);
      result_t want;
      want.cell_out = 1'b0;
      case (cmd.opcode)
        OP_WRITE: begin
          if (cmd.row < Side && cmd.column < Side)
            cells[page][cmd.row][cmd.column] = cmd.cell_in;
        end
        OP_READ: begin
          if (cmd.row < Side && cmd.column < Side)
            want.cell_out = cells[page][cmd.row][cmd.column];
          if (want.cell_out) live_reads++;
        end
        OP_STEP: advance();
        default: ;
      endcase
      want.generation = gen_count;
      expected_results.push_back(want);
    endfunction

    task check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected (cell %0b gen %0d)",
                                  got.cell_out, got.generation));
        return;
      end
      want = expected_results.pop_front();
      if (got.cell_out !== want.cell_out)
        report_mismatch($sformatf("cell_out %0b, want %0b", got.cell_out, want.cell_out));
      if (got.generation !== want.generation)
        report_mismatch($sformatf("generation %0d, want %0d",
                                  got.generation, want.generation));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  cmd_t                 cmd_i = '0;
  logic                 done_o;
  result_t              result_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  mask_t                cfg_data_i = '0;

  life_predictor pred = new();
  int            cmds_sent;
  int            rule_settings;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  life_like_automaton_step_core #(
    .SIDE(Side)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .cmd_i      (cmd_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // Monitor: results first, then the command and config transactions
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o === 1'b1) pred.check_result(result_o);
      if (start_i && busy_o === 1'b0) pred.accept_cmd(cmd_i);
      if (cfg_valid_i && cfg_ready_o === 1'b1) pred.set_register(cfg_index_i, cfg_data_i);
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  function automatic cmd_t make_cmd(op_e op, int r, int c, logic v);
    cmd_t cmd;
    cmd.opcode  = op;
    cmd.row     = RowW'(r);
    cmd.column  = ColW'(c);
    cmd.cell_in = v;
    return cmd;
  endfunction

  function automatic int wrap_coord(int base, int off);
    return (base + off + Side) % Side;
  endfunction

  // Hold start until the command transaction is taken; start stays high
  task automatic send_cmd(cmd_t cmd);
    start_i <= 1'b1;
    cmd_i   <= cmd;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    cmds_sent++;
  endtask

  // Sender gap, with junk on the command bus
  task automatic idle(int cycles);
    start_i <= 1'b0;
    cmd_i   <= make_cmd(op_e'($urandom_range(3)), $urandom_range(Side - 1),
                        $urandom_range(Side - 1), $urandom_range(1));
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic maybe_idle(int pct);
    if ($urandom_range(99) < pct) idle($urandom_range(1, 13));
  endtask

  // One edge first so the monitor has logged the last accepted command
  task automatic wait_for_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pred.pending() != 0) @(posedge clk_i);
  endtask

  // Valid stays high across back-to-back writes; the caller lowers it
  task automatic cfg_write(logic [CfgIdxW-1:0] idx, mask_t data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
  endtask

  // Rule change only once the core has drained
  task automatic program_rules(mask_t b, mask_t s, bit touch_spare);
    wait_for_results();
    @(posedge clk_i);
    cfg_write(CFG_BIRTH, b);
    if (touch_spare) cfg_write(CfgSpareLo, mask_t'($urandom));
    cfg_write(CFG_SURVIVE, s);
    if (touch_spare) cfg_write(CfgSpareHi, mask_t'($urandom));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    rule_settings++;
  endtask

  function automatic int pick_center();
    case ($urandom_range(3))
      0:       return 0;
      1:       return Side - 1;
      default: return $urandom_range(Side - 1);
    endcase
  endfunction

  // Seed a small patch, evolve it, then probe around it
  task automatic run_episode(int idle_pct);
    int r0, c0, n;
    r0 = pick_center();
    c0 = pick_center();
    n = $urandom_range(3, 12);
    repeat (n) begin
      send_cmd(make_cmd(OP_WRITE, wrap_coord(r0, int'($urandom_range(4)) - 2),
                        wrap_coord(c0, int'($urandom_range(4)) - 2),
                        $urandom_range(3) != 0));
      maybe_idle(idle_pct);
    end
    n = $urandom_range(0, 2);
    repeat (n) begin
      send_cmd(make_cmd(OP_STEP, $urandom_range(Side - 1), $urandom_range(Side - 1),
                        $urandom_range(1)));
      maybe_idle(idle_pct);
    end
    n = $urandom_range(2, 8);
    repeat (n) begin
      send_cmd(make_cmd(OP_READ, wrap_coord(r0, int'($urandom_range(6)) - 3),
                        wrap_coord(c0, int'($urandom_range(6)) - 3), $urandom_range(1)));
      maybe_idle(idle_pct);
    end
    // occasional noise, any opcode anywhere
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(1, 2);
      repeat (n) begin
        send_cmd(make_cmd(op_e'($urandom_range(3)), $urandom_range(Side - 1),
                          $urandom_range(Side - 1), $urandom_range(1)));
        maybe_idle(idle_pct);
      end
    end
  endtask

  task automatic run_rule_phase(int idle_pct);
    int stop_at;
    stop_at = cmds_sent + ItemsPerRule;
    while (cmds_sent < stop_at) run_episode(idle_pct);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    cmds_sent = 0;
    rule_settings = 1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: corners, unused opcode, blinker across the corner seams
    send_cmd(make_cmd(OP_READ, 0, 0, 1'b0));
    send_cmd(make_cmd(op_e'(OpUnused), Side - 1, Side - 1, 1'b1));
    send_cmd(make_cmd(OP_WRITE, Side - 1, Side - 1, 1'b1));
    send_cmd(make_cmd(OP_READ, Side - 1, Side - 1, 1'b1));
    idle(3);
    send_cmd(make_cmd(OP_WRITE, 0, Side - 2, 1'b1));
    send_cmd(make_cmd(OP_WRITE, 0, Side - 1, 1'b1));
    send_cmd(make_cmd(OP_WRITE, 0, 0, 1'b1));
    send_cmd(make_cmd(OP_WRITE, Side - 1, Side - 1, 1'b0));
    send_cmd(make_cmd(OP_STEP, Side - 1, 0, 1'b1));
    send_cmd(make_cmd(OP_READ, Side - 1, Side - 1, 1'b0));
    send_cmd(make_cmd(OP_READ, 1, Side - 1, 1'b0));
    send_cmd(make_cmd(OP_READ, 0, Side - 2, 1'b0));
    send_cmd(make_cmd(OP_READ, 0, 0, 1'b0));
    idle(1);
    send_cmd(make_cmd(OP_STEP, 0, Side - 1, 1'b0));
    send_cmd(make_cmd(OP_READ, 0, 0, 1'b1));
    send_cmd(make_cmd(op_e'(OpUnused), 0, 0, 1'b0));
    send_cmd(make_cmd(OP_READ, Side - 1, 0, 1'b1));

    // Random episodes under a series of rules, extremes included
    run_rule_phase(15);
    program_rules('0, '0, 1'b0);
    run_rule_phase(0);
    program_rules('1, '1, 1'b0);
    run_rule_phase(50);
    program_rules(BirthMaskRst, SurviveMaskRst, 1'b1);
    run_rule_phase(15);
    program_rules(mask_t'($urandom), mask_t'($urandom), 1'b0);
    run_rule_phase(0);
    program_rules('1, '0, 1'b0);
    run_rule_phase(50);
    program_rules('0, '1, 1'b0);
    run_rule_phase(15);
    program_rules(mask_t'(72), SurviveMaskRst, 1'b0);   // B36/S23
    run_rule_phase(50);
    program_rules(mask_t'($urandom), mask_t'($urandom), 1'b0);
    run_rule_phase(15);
    program_rules(BirthMaskRst, SurviveMaskRst, 1'b0);
    run_rule_phase(0);

    // Drain and let the core settle
    wait_for_results();
    repeat (Side + 8) @(posedge clk_i);
    if (pred.pending() != 0)
      pred.report_mismatch($sformatf("%0d results never arrived", pred.pending()));

    $display("Ran %0d commands under %0d rule settings: %0d generations, %0d live reads.",
             cmds_sent, rule_settings, pred.steps_seen, pred.live_reads);
    $display("Mismatches counted: %0d", pred.mismatches);
    if (pred.mismatches == 0) begin
      $display("life_like_automaton_step_core_tb passed");
    end else begin
      $display("life_like_automaton_step_core_tb failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(20_000_000);
    $display("life_like_automaton_step_core_tb failed");
    $finish;
  end

endmodule

### files.f
hdl/llas_pkg.sv
hdl/llas_row_cell.sv
hdl/llas_rule_row.sv
hdl/life_like_automaton_step_core.sv
tb/life_like_automaton_step_core_tb.sv
